>>> sv/lap5_pkg.sv
// ----------------------------------------------------------------------------
// lap5_pkg
// Shared constants, types and helpers of the 5x5 Laplacian edge filter.
// ----------------------------------------------------------------------------
package lap5_pkg;

    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned MIN_DIM    = 5;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned LINES   = 4;                       // line stores
    localparam int unsigned WIN     = 5;                       // window edge
    localparam int unsigned COL_W   = $clog2(MAX_WIDTH);       // column index
    localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);      // output row index
    localparam int unsigned WDIM_W  = $clog2(MAX_WIDTH + 1);   // clamped width
    localparam int unsigned HDIM_W  = $clog2(MAX_HEIGHT + 1);  // clamped height
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned RST_WIDTH  = 640;
    localparam int unsigned RST_HEIGHT = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int unsigned RSUM_W = PIX_W + 3;   // sum of five pixels
    localparam int unsigned TOT_W  = PIX_W + 5;   // sum of 25 pixels
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [LINES-1:0][PIX_W-1:0] t_lines;
    typedef logic [WIN-1:0][PIX_W-1:0] t_column;

    typedef struct packed {
        logic emit;
        logic last;
        logic interior;
    } t_tag;

    typedef struct packed {
        t_pix pixel;
        logic last;
    } t_result;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned hi);
        int unsigned x;
        x = 32'(v);
        if (x < MIN_DIM) begin
            return MIN_DIM;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

>>> sv/lap5_in_if.sv
// ----------------------------------------------------------------------------
// lap5_in_if
// Pixel request channel into the edge filter.
// ----------------------------------------------------------------------------
interface lap5_in_if;
    logic                      valid;
    logic                      ready;
    logic [lap5_pkg::PIX_W-1:0] pixel_in;
    logic                      flush;

    modport source (output valid, output pixel_in, output flush, input ready);
    modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

>>> sv/lap5_out_if.sv
// ----------------------------------------------------------------------------
// lap5_out_if
// Edge pixel request channel out of the edge filter.
// ----------------------------------------------------------------------------
interface lap5_out_if;
    logic                      valid;
    logic                      ready;
    logic [lap5_pkg::PIX_W-1:0] pixel_out;
    logic                      last_pixel;

    modport source (output valid, output pixel_out, output last_pixel, input ready);
    modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

>>> sv/lap5_ram.sv
// ----------------------------------------------------------------------------
// lap5_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lap5_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/lap5_line_buf.sv
// ----------------------------------------------------------------------------
// lap5_line_buf
// Four line stores packed as one column word per image column. Each request
// reads its column, then writes it back shifted up by one line with the new
// pixel at the bottom.
// ----------------------------------------------------------------------------
module lap5_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [lap5_pkg::COL_W-1:0] i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [lap5_pkg::COL_W-1:0] i_wr_addr,
    input  lap5_pkg::t_pix            i_px,
    output lap5_pkg::t_lines          o_rows
);

    lap5_pkg::t_lines ram_rdata;
    lap5_pkg::t_lines wr_word;
    logic             r_fwd_hit;
    lap5_pkg::t_lines r_fwd_word;

    always_comb begin
        for (int r = 0; r < lap5_pkg::LINES - 1; r++) begin
            wr_word[r] = o_rows[r + 1];
        end
        wr_word[lap5_pkg::LINES-1] = i_px;
    end

    lap5_ram #(
        .WIDTH (lap5_pkg::LINES * lap5_pkg::PIX_W),
        .DEPTH (lap5_pkg::MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (wr_word),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_rdata)
    );

    // read of the column being written in the same cycle returns the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_word <= wr_word;
        end
    end

    assign o_rows = r_fwd_hit ? r_fwd_word : ram_rdata;

endmodule

>>> sv/lap5_kernel.sv
// ----------------------------------------------------------------------------
// lap5_kernel
// 5x5 window registers and the Laplacian sum: row sums in one stage, total
// minus 25x centre and clamp in the next.
// ----------------------------------------------------------------------------
module lap5_kernel (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lap5_pkg::t_tag     i_tag,
    input  lap5_pkg::t_column  i_column,
    output logic               o_valid,
    output lap5_pkg::t_result  o_result
);

    localparam int unsigned CTR = lap5_pkg::WIN / 2;

    lap5_pkg::t_pix r_win [lap5_pkg::WIN][lap5_pkg::WIN];

    logic           r_s2_valid;
    lap5_pkg::t_tag r_s2_tag;
    logic           r_s3_valid;
    lap5_pkg::t_tag r_s3_tag;

    logic [lap5_pkg::RSUM_W-1:0] n_rsum [lap5_pkg::WIN];
    logic [lap5_pkg::RSUM_W-1:0] r_rsum [lap5_pkg::WIN];
    logic [lap5_pkg::TOT_W-1:0]  n_c25;
    logic [lap5_pkg::TOT_W-1:0]  r_c25;
    logic [lap5_pkg::TOT_W-1:0]  total;
    logic [lap5_pkg::TOT_W:0]    diff;
    lap5_pkg::t_pix              pix;

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            for (int r = 0; r < lap5_pkg::WIN; r++) begin
                for (int c = 0; c < lap5_pkg::WIN - 1; c++) begin
                    r_win[r][c] <= r_win[r][c + 1];
                end
                r_win[r][lap5_pkg::WIN-1] <= i_column[r];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < lap5_pkg::WIN; r++) begin
            n_rsum[r] = '0;
            for (int c = 0; c < lap5_pkg::WIN; c++) begin
                n_rsum[r] = n_rsum[r] + lap5_pkg::RSUM_W'(r_win[r][c]);
            end
        end
        // 25 = 16 + 8 + 1
        n_c25 = lap5_pkg::TOT_W'({r_win[CTR][CTR], 4'b0000})
              + lap5_pkg::TOT_W'({r_win[CTR][CTR], 3'b000})
              + lap5_pkg::TOT_W'(r_win[CTR][CTR]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_tag <= i_tag;
            r_s3_tag <= r_s2_tag;
            r_rsum   <= n_rsum;
            r_c25    <= n_c25;
        end
    end

    always_comb begin
        total = '0;
        for (int r = 0; r < lap5_pkg::WIN; r++) begin
            total = total + lap5_pkg::TOT_W'(r_rsum[r]);
        end
        diff = {1'b0, total} - {1'b0, r_c25};
        if (!r_s3_tag.interior || diff[lap5_pkg::TOT_W]) begin
            pix = '0;
        end else if (diff > (lap5_pkg::TOT_W + 1)'(lap5_pkg::PIX_MAX)) begin
            pix = lap5_pkg::PIX_MAX;
        end else begin
            pix = lap5_pkg::PIX_W'(diff);
        end
    end

    assign o_valid         = r_s3_valid && r_s3_tag.emit;
    assign o_result.pixel  = pix;
    assign o_result.last   = r_s3_tag.last;

endmodule

>>> sv/lap5_skid.sv
// ----------------------------------------------------------------------------
// lap5_skid
// Output register plus one skid entry; the pipeline advances while the skid
// entry is empty.
// ----------------------------------------------------------------------------
module lap5_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lap5_pkg::t_result i_result,
    output logic              o_ready,
    lap5_out_if.source        o_pix
);

    logic              r_out_valid;
    lap5_pkg::t_result r_out;
    logic              r_skid_valid;
    lap5_pkg::t_result r_skid;

    logic load_out;
    logic load_skid;
    logic drain_skid;

    always_comb begin
        drain_skid = r_skid_valid && o_pix.ready;
        load_out   = !r_skid_valid && i_valid && (!r_out_valid || o_pix.ready);
        load_skid  = !r_skid_valid && i_valid && r_out_valid && !o_pix.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (o_pix.ready) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (!r_out_valid || o_pix.ready) begin
                r_out_valid <= i_valid;
            end else if (i_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_skid) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= i_result;
        end
        if (load_skid) begin
            r_skid <= i_result;
        end
    end

    assign o_ready          = !r_skid_valid;
    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_out  = r_out.pixel;
    assign o_pix.last_pixel = r_out.last;

endmodule

>>> sv/laplacian_5x5_edge_filter_core.sv
// ----------------------------------------------------------------------------
// laplacian_5x5_edge_filter_core
// 5x5 Laplacian edge filter over a raster pixel stream, line stores in RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                 | handshake
//  i_pix    | in  | pixel_in[7:0], flush    | valid/ready
//  o_pix    | out | pixel_out[7:0], last    | valid/ready
//  i_cfg_*  | in  | idx[0], data[10:0]      | write enable, no wait
//
//  One request per clock sustained while the output is not stalled. The
//  4-line column RAM (one read, one write per cycle) sets the pipeline: fetch,
//  window shift, row sums, total; the output register follows the total.
//  Results start 2*width+2 requests into a frame. Synchronous reset clears
//  counters and valids; line stores and window hold garbage until written.
//  A stalled output fills one skid entry, then i_pix.ready drops.
// ----------------------------------------------------------------------------
module laplacian_5x5_edge_filter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lap5_in_if.sink                       i_pix,
    lap5_out_if.source                    o_pix,
    input  logic                          i_cfg_we,
    input  logic [lap5_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lap5_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam logic [1:0] ROW_SAT = 2'd3;

    logic [lap5_pkg::WDIM_W-1:0] r_width;
    logic [lap5_pkg::HDIM_W-1:0] r_height;

    logic [lap5_pkg::COL_W-1:0] r_col;
    logic [1:0]                 r_row;
    logic [lap5_pkg::COL_W-1:0] r_ocol;
    logic [lap5_pkg::ROW_W-1:0] r_orow;
    logic [lap5_pkg::COL_W-1:0] n_col;
    logic [1:0]                 n_row;
    logic [lap5_pkg::COL_W-1:0] n_ocol;
    logic [lap5_pkg::ROW_W-1:0] n_orow;

    logic [lap5_pkg::COL_W-1:0] w_m1;
    logic [lap5_pkg::COL_W-1:0] w_m3;
    logic [lap5_pkg::ROW_W-1:0] h_m1;
    logic [lap5_pkg::ROW_W-1:0] h_m3;

    logic           en;
    logic           accept;
    lap5_pkg::t_tag tag;
    lap5_pkg::t_pix px;

    logic                       r_s1_valid;
    lap5_pkg::t_tag             r_s1_tag;
    lap5_pkg::t_pix             r_s1_px;
    logic [lap5_pkg::COL_W-1:0] r_s1_col;

    lap5_pkg::t_lines  lb_rows;
    lap5_pkg::t_column column;
    logic              k_valid;
    lap5_pkg::t_result k_result;

    assign w_m1 = lap5_pkg::COL_W'(r_width - lap5_pkg::WDIM_W'(1));
    assign w_m3 = lap5_pkg::COL_W'(r_width - lap5_pkg::WDIM_W'(3));
    assign h_m1 = lap5_pkg::ROW_W'(r_height - lap5_pkg::HDIM_W'(1));
    assign h_m3 = lap5_pkg::ROW_W'(r_height - lap5_pkg::HDIM_W'(3));

    assign accept      = i_pix.valid && en;
    assign i_pix.ready = en;
    assign px          = i_pix.flush ? '0 : i_pix.pixel_in;

    always_comb begin
        tag.emit     = (r_row == ROW_SAT) || ((r_row == 2'd2) && (r_col >= 2));
        tag.last     = (r_ocol == w_m1) && (r_orow == h_m1);
        tag.interior = (r_orow >= 2) && (r_orow <= h_m3)
                    && (r_ocol >= 2) && (r_ocol <= w_m3);
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (accept) begin
            if (r_col == w_m1) begin
                n_col = '0;
                if (r_row != ROW_SAT) begin
                    n_row = r_row + 2'd1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
            if (tag.emit) begin
                if (tag.last) begin
                    // frame done: next request starts a new frame
                    n_col  = '0;
                    n_row  = '0;
                    n_ocol = '0;
                    n_orow = '0;
                end else if (r_ocol == w_m1) begin
                    n_ocol = '0;
                    n_orow = r_orow + 1'b1;
                end else begin
                    n_ocol = r_ocol + 1'b1;
                end
            end
        end
        if (i_cfg_we) begin
            n_col  = '0;
            n_row  = '0;
            n_ocol = '0;
            n_orow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lap5_pkg::WDIM_W'(lap5_pkg::RST_WIDTH);
            r_height <= lap5_pkg::HDIM_W'(lap5_pkg::RST_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            if (i_cfg_we) begin
                if (i_cfg_idx == lap5_pkg::REG_IMAGE_WIDTH) begin
                    r_width <= lap5_pkg::WDIM_W'(
                        lap5_pkg::clamp_dim(i_cfg_data, lap5_pkg::MAX_WIDTH));
                end else if (i_cfg_idx == lap5_pkg::REG_IMAGE_HEIGHT) begin
                    r_height <= lap5_pkg::HDIM_W'(
                        lap5_pkg::clamp_dim(i_cfg_data, lap5_pkg::MAX_HEIGHT));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_tag <= tag;
            r_s1_px  <= px;
            r_s1_col <= r_col;
        end
    end

    lap5_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en),
        .i_rd_addr (r_col),
        .i_wr_en   (en && r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_px      (r_s1_px),
        .o_rows    (lb_rows)
    );

    always_comb begin
        for (int r = 0; r < lap5_pkg::LINES; r++) begin
            column[r] = lb_rows[r];
        end
        column[lap5_pkg::WIN-1] = r_s1_px;
    end

    lap5_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s1_valid),
        .i_tag    (r_s1_tag),
        .i_column (column),
        .o_valid  (k_valid),
        .o_result (k_result)
    );

    lap5_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (k_valid),
        .i_result (k_result),
        .o_ready  (en),
        .o_pix    (o_pix)
    );

endmodule

>>> sv/lap5_checker.sv
// ----------------------------------------------------------------------------
// lap5_checker
// Port-level checks on the edge filter, bound to the top level.
// ----------------------------------------------------------------------------
module lap5_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [lap5_pkg::PIX_W-1:0] i_out_pixel,
    input logic                      i_out_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel)
                                        && $stable(i_out_last))
        else $error("output request changed while stalled");

    // input backpressure only with a result waiting
    a_bp_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled without a pending result");

    // backpressure persists while the output is not taken
    a_bp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && !i_out_ready |=> !i_in_ready)
        else $error("input ready rose while results still blocked");

    // reset empties the output side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("output not cleared by reset");

endmodule

bind laplacian_5x5_edge_filter_core lap5_checker u_lap5_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out),
    .i_out_last  (o_pix.last_pixel)
);

>>> dv/laplacian_5x5_edge_filter_core_test.sv
// ----------------------------------------------------------------------------
// laplacian_5x5_edge_filter_core_test
// Self-checking bench for the 5x5 Laplacian edge filter. Pixel requests go
// in as raster frames followed by their flush tail. A local model of the
// line stores and window predicts every edge pixel and the frame-end mark.
// A check process compares each output request against the oldest
// prediction. Covered: hand-built windows, extreme and out-of-range frame
// sizes, random frames (some broken off early), and a long output stall.
// ----------------------------------------------------------------------------
module laplacian_5x5_edge_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = 12;       // pipeline depth plus margin
    localparam int unsigned STALL_CYCLES  = 400;
    localparam int unsigned RANDOM_ITEMS  = 1260;
    localparam int unsigned TALL_ITEMS    = 150;      // slice of a 1024-row frame
    localparam int unsigned NO_LIMIT      = 32'hFFFF_FFFF;
    localparam int unsigned FLUSH_PCT     = 8;        // flush requests inside the image
    localparam int unsigned TAIL_PIX_PCT  = 25;       // pixel requests inside the tail

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lap5_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [lap5_pkg::CFG_W-1:0]     i_cfg_data;

    lap5_in_if  pix_req ();
    lap5_out_if edge_rsp ();

    laplacian_5x5_edge_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_req),
        .o_pix      (edge_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    int unsigned src_idle_pct = 7;
    int unsigned snk_idle_pct = 77;
    int unsigned hold_request = 0;
    int unsigned hold_taken   = 0;
    int unsigned hold_left    = 0;
    int unsigned items_sent   = 0;
    int unsigned err_count    = 0;

    // filter model state
    logic [lap5_pkg::CFG_W-1:0] width_reg;
    logic [lap5_pkg::CFG_W-1:0] height_reg;
    lap5_pkg::t_pix             line_mem [lap5_pkg::LINES][lap5_pkg::MAX_WIDTH];
    lap5_pkg::t_pix             win [lap5_pkg::WIN][lap5_pkg::WIN];
    int unsigned                col_pos;
    int unsigned                row_pos;
    int unsigned                out_index;
    lap5_pkg::t_result          edge_due [$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned active_dim(input logic [lap5_pkg::CFG_W-1:0] raw,
                                               input int unsigned hi);
        if (raw < lap5_pkg::MIN_DIM) begin
            return lap5_pkg::MIN_DIM;
        end
        return (raw > hi) ? hi : int'(raw);
    endfunction

    function automatic void filter_pixel(input lap5_pkg::t_pix pix_in, input logic is_flush);
        int unsigned       w;
        int unsigned       h;
        int unsigned       col;
        int unsigned       row;
        int unsigned       k;
        int unsigned       orow;
        int unsigned       ocol;
        lap5_pkg::t_pix    column [lap5_pkg::WIN];
        int                sum;
        bit                emit;
        lap5_pkg::t_result res;
        w   = active_dim(width_reg, lap5_pkg::MAX_WIDTH);
        h   = active_dim(height_reg, lap5_pkg::MAX_HEIGHT);
        col = (col_pos >= w) ? w - 1 : col_pos;
        row = row_pos;
        for (int r = 0; r < lap5_pkg::LINES; r++) begin
            column[r] = line_mem[r][col];
        end
        column[lap5_pkg::WIN-1] = is_flush ? lap5_pkg::t_pix'(0) : pix_in;
        for (int r = 0; r < lap5_pkg::LINES; r++) begin
            line_mem[r][col] = column[r+1];
        end
        for (int r = 0; r < lap5_pkg::WIN; r++) begin
            for (int c = 0; c < lap5_pkg::WIN - 1; c++) begin
                win[r][c] = win[r][c+1];
            end
            win[r][lap5_pkg::WIN-1] = column[r];
        end
        emit = (row > 2) || (row == 2 && col >= 2);
        if (col + 1 >= w) begin
            col_pos = 0;
            if (row < 'hFFFF) begin
                row_pos = row + 1;
            end
        end else begin
            col_pos = col + 1;
        end
        if (!emit) begin
            return;
        end
        k        = out_index;
        orow     = k / w;
        ocol     = k % w;
        res.last = (k + 1 >= w * h);
        sum      = 0;
        if (orow >= 2 && orow + 2 < h && ocol >= 2 && ocol + 2 < w) begin
            for (int r = 0; r < lap5_pkg::WIN; r++) begin
                for (int c = 0; c < lap5_pkg::WIN; c++) begin
                    sum += int'(win[r][c]);
                end
            end
            // 24 neighbours minus 24x centre: drop the centre once more
            sum -= lap5_pkg::WIN * lap5_pkg::WIN
                 * int'(win[lap5_pkg::WIN/2][lap5_pkg::WIN/2]);
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > int'(lap5_pkg::PIX_MAX)) begin
                sum = int'(lap5_pkg::PIX_MAX);
            end
        end
        res.pixel = lap5_pkg::t_pix'(sum);
        edge_due.push_back(res);
        if (res.last) begin
            col_pos   = 0;
            row_pos   = 0;
            out_index = 0;
        end else begin
            out_index = k + 1;
        end
    endfunction

    function automatic lap5_pkg::t_pix random_pixel();
        case ($urandom_range(0, 7))
            0: begin
                return lap5_pkg::t_pix'(0);
            end
            1: begin
                return lap5_pkg::PIX_MAX;
            end
            default: begin
                return lap5_pkg::t_pix'($urandom);
            end
        endcase
    endfunction

    function automatic logic [lap5_pkg::CFG_W-1:0] random_dim();
        if ($urandom_range(0, 7) == 0) begin
            return lap5_pkg::CFG_W'($urandom_range(0, lap5_pkg::MIN_DIM - 1));
        end
        return lap5_pkg::CFG_W'($urandom_range(lap5_pkg::MIN_DIM, 12));
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic send_item(input lap5_pkg::t_pix pix, input logic is_flush);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_req.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_req.valid    <= 1'b1;
        pix_req.pixel_in <= pix;
        pix_req.flush    <= is_flush;
        @(posedge i_clk);
        while (!pix_req.ready) begin
            @(posedge i_clk);
        end
        filter_pixel(pix, is_flush);
        items_sent++;
    endtask

    // drain: idle input, all edge pixels back, pipeline empty
    task automatic settle();
        pix_req.valid <= 1'b0;
        while (edge_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lap5_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lap5_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lap5_pkg::REG_IMAGE_WIDTH) begin
            width_reg = data;
        end else begin
            height_reg = data;
        end
        col_pos   = 0;
        row_pos   = 0;
        out_index = 0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [lap5_pkg::CFG_W-1:0] raw_w,
                                input logic [lap5_pkg::CFG_W-1:0] raw_h);
        settle();
        write_reg(lap5_pkg::REG_IMAGE_WIDTH, raw_w);
        write_reg(lap5_pkg::REG_IMAGE_HEIGHT, raw_h);
    endtask

    // image pixels then the flush tail; max_items cuts a frame short
    task automatic send_frame(input int unsigned flush_pct, input int unsigned tail_pct,
                              input int unsigned max_items);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        w     = active_dim(width_reg, lap5_pkg::MAX_WIDTH);
        h     = active_dim(height_reg, lap5_pkg::MAX_HEIGHT);
        total = w * h + 2 * w + 2;
        for (int unsigned n = 0; n < total && n < max_items; n++) begin
            if (n < w * h) begin
                send_item(random_pixel(), $urandom_range(0, 99) < flush_pct);
            end else begin
                send_item(random_pixel(), $urandom_range(0, 99) >= tail_pct);
            end
        end
    endtask

    task automatic test_directed_windows();
        set_geometry(lap5_pkg::CFG_W'(5), lap5_pkg::CFG_W'(5));
        // bright surround, dark centre from a flush request carrying 255
        for (int i = 0; i < 25; i++) begin
            send_item(lap5_pkg::PIX_MAX, i == 12);
        end
        for (int i = 0; i < 12; i++) begin
            send_item(lap5_pkg::t_pix'(0), 1'b1);
        end
        // lone bright centre clamps at zero; pixels stand in for the tail
        for (int i = 0; i < 25; i++) begin
            send_item((i == 12) ? lap5_pkg::PIX_MAX : lap5_pkg::t_pix'(0), 1'b0);
        end
        for (int i = 0; i < 12; i++) begin
            send_item(lap5_pkg::PIX_MAX, 1'b0);
        end
    endtask

    task automatic test_geometry_extremes();
        set_geometry(lap5_pkg::CFG_W'(lap5_pkg::MIN_DIM - 1), lap5_pkg::CFG_W'(0));
        send_frame(FLUSH_PCT, TAIL_PIX_PCT, NO_LIMIT);
        // height clamps to the maximum; only the top of the frame is sent
        set_geometry(lap5_pkg::CFG_W'(0), '1);
        send_frame(FLUSH_PCT, TAIL_PIX_PCT, TALL_ITEMS);
    endtask

    task automatic test_random_frames(input int unsigned quota);
        int unsigned stop_at;
        int unsigned total;
        stop_at = items_sent + quota;
        set_geometry(random_dim(), random_dim());
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    set_geometry(random_dim(), random_dim());
                    send_frame(FLUSH_PCT, TAIL_PIX_PCT, NO_LIMIT);
                end
                3: begin
                    // broken frame: stop before the last output, restart by a write
                    total = active_dim(width_reg, lap5_pkg::MAX_WIDTH)
                          * active_dim(height_reg, lap5_pkg::MAX_HEIGHT)
                          + 2 * active_dim(width_reg, lap5_pkg::MAX_WIDTH) + 2;
                    send_frame(FLUSH_PCT, TAIL_PIX_PCT, $urandom_range(1, total - 1));
                    set_geometry(random_dim(), random_dim());
                end
                default: begin
                    send_frame(FLUSH_PCT, TAIL_PIX_PCT, NO_LIMIT);
                end
            endcase
        end
    endtask

    task automatic test_output_backpressure();
        set_geometry(lap5_pkg::CFG_W'(10), lap5_pkg::CFG_W'(10));
        hold_request++;
        send_frame(FLUSH_PCT, TAIL_PIX_PCT, NO_LIMIT);
    endtask

    always @(posedge i_clk) begin
        if (hold_request != hold_taken) begin
            hold_taken = hold_request;
            hold_left  = STALL_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            edge_rsp.ready <= 1'b0;
        end else begin
            edge_rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        lap5_pkg::t_result want;
        if (i_rst_n && edge_rsp.valid && edge_rsp.ready) begin
            if (edge_due.size() == 0) begin
                report_mismatch($sformatf("edge pixel %0d last %0b with none expected",
                                          edge_rsp.pixel_out, edge_rsp.last_pixel));
            end else begin
                want = edge_due.pop_front();
                if (edge_rsp.pixel_out !== want.pixel) begin
                    report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                              edge_rsp.pixel_out, want.pixel));
                end
                if (edge_rsp.last_pixel !== want.last) begin
                    report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                              edge_rsp.last_pixel, want.last));
                end
            end
        end
    end

    initial begin
        pix_req.valid    = 1'b0;
        pix_req.pixel_in = '0;
        pix_req.flush    = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = lap5_pkg::REG_IMAGE_WIDTH;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        width_reg        = lap5_pkg::CFG_W'(lap5_pkg::RST_WIDTH);
        height_reg       = lap5_pkg::CFG_W'(lap5_pkg::RST_HEIGHT);
        col_pos          = 0;
        row_pos          = 0;
        out_index        = 0;
        for (int r = 0; r < lap5_pkg::LINES; r++) begin
            for (int c = 0; c < lap5_pkg::MAX_WIDTH; c++) begin
                line_mem[r][c] = '0;
            end
        end
        for (int r = 0; r < lap5_pkg::WIN; r++) begin
            for (int c = 0; c < lap5_pkg::WIN; c++) begin
                win[r][c] = '0;
            end
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_windows();
        test_geometry_extremes();
        test_random_frames(RANDOM_ITEMS / 3);
        src_idle_pct = 77;
        snk_idle_pct = 7;
        test_random_frames(RANDOM_ITEMS / 3);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_frames(RANDOM_ITEMS / 3);
        test_output_backpressure();
        settle();

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lap5_pkg.sv
sv/lap5_in_if.sv
sv/lap5_out_if.sv
sv/lap5_ram.sv
sv/lap5_line_buf.sv
sv/lap5_kernel.sv
sv/lap5_skid.sv
sv/laplacian_5x5_edge_filter_core.sv
sv/lap5_checker.sv
dv/laplacian_5x5_edge_filter_core_test.sv
